@@ rtl/pmds_pkg.sv @@
// ----------------------------------------------------------------------------
// pmds_pkg
// Shared types and codes of the page-mode DRAM access sequencer.
// ----------------------------------------------------------------------------
package pmds_pkg;

    localparam int unsigned ADDR_W = 12;
    localparam int unsigned DATA_W = 8;
    localparam int unsigned HOLD_W = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 4;
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 32;

    typedef enum logic [2:0] {
        OP_READ       = 3'd0,
        OP_WRITE      = 3'd1,
        OP_PAGE_READ  = 3'd2,
        OP_PAGE_WRITE = 3'd3,
        OP_REFRESH    = 3'd4
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EDO_MODE       = 3'd0,
        CFG_CAC_WAIT       = 3'd1,
        CFG_CAS_WAIT       = 3'd2,
        CFG_RAS_WAIT       = 3'd3,
        CFG_PRECHARGE_WAIT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              edo_mode;
        logic [HOLD_W-1:0] cac_wait;
        logic [HOLD_W-1:0] cas_wait;
        logic [HOLD_W-1:0] ras_wait;
        logic [HOLD_W-1:0] precharge_wait;
    } t_cfg;

    // classified request handed from front to back
    typedef struct packed {
        logic              is_refresh;
        logic              is_write;
        logic              drive_row;
        logic              close_first;
        logic              need_row;
        logic              end_close;
        logic [ADDR_W-1:0] close_addr;
        logic [ADDR_W-1:0] row;
        logic [ADDR_W-1:0] column;
        logic [DATA_W-1:0] write_data;
    } t_desc;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_ROW_SETUP,
        ST_RAS,
        ST_COLUMN,
        ST_CAS_LOW,
        ST_CAS_HIGH,
        ST_PRECHARGE,
        ST_REF_CAS,
        ST_REF_RAS,
        ST_REF_PRE
    } t_state;

    typedef struct packed {
        logic              ras_n;
        logic              cas_n;
        logic              we_n;
        logic [ADDR_W-1:0] addr_out;
        logic [DATA_W-1:0] data_out;
        logic              drive_data;
        logic              sample_data;
        logic [HOLD_W-1:0] hold_cycles;
        logic              last;
    } t_phase;

endpackage

@@ rtl/page_mode_dram_access_sequencer.sv @@
// ----------------------------------------------------------------------------
// page_mode_dram_access_sequencer
// Turns DRAM access requests into runs of pin-phase words.
// ----------------------------------------------------------------------------
// A request beat is taken whenever the two-entry request queue has room;
// the phase sequencer then sends one phase word per cycle while the phase
// channel is ready, and a request yields one phase word per phase: 3 for a
// page beat to the open row that keeps it open, 4 if that beat closes it, up
// to 7 for an access that first closes another row (refresh 3 or 4). The
// sequencer is the rate-setting unit; the queue lets one further request be
// taken while it works. Undefined opcodes are taken and dropped.
// Config writes apply from the next cycle.
// ----------------------------------------------------------------------------
module page_mode_dram_access_sequencer #(
    parameter int unsigned ADDR_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // row[11:0], column[23:12], write_data[31:24]
    input  logic [pmds_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic [2:0]                         i_s_axis_tuser,   // opcode[2:0]
    input  logic                               i_s_axis_tlast,   // close_row
    // phase channel
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // ras_n[0], cas_n[1], we_n[2], addr_out[14:3], data_out[22:15],
    // drive_data[23], sample_data[24], hold_cycles[28:25], zero[31:29]
    output logic [pmds_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                               o_m_axis_tlast,   // last
    // configuration
    input  logic                               i_cfg_we,
    input  logic [pmds_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pmds_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    pmds_pkg::t_cfg   r_cfg;
    pmds_pkg::t_desc  w_front_desc;
    pmds_pkg::t_desc  w_head_desc;
    pmds_pkg::t_phase w_phase;
    logic             w_accept;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;

    assign o_s_axis_tready = !w_full;
    assign w_accept        = i_s_axis_tvalid && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.edo_mode       <= 1'b0;
            r_cfg.cac_wait       <= 4'd2;
            r_cfg.cas_wait       <= 4'd1;
            r_cfg.ras_wait       <= 4'd3;
            r_cfg.precharge_wait <= 4'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pmds_pkg::CFG_EDO_MODE:       r_cfg.edo_mode       <= i_cfg_wdata[0];
                pmds_pkg::CFG_CAC_WAIT:       r_cfg.cac_wait       <= i_cfg_wdata;
                pmds_pkg::CFG_CAS_WAIT:       r_cfg.cas_wait       <= i_cfg_wdata;
                pmds_pkg::CFG_RAS_WAIT:       r_cfg.ras_wait       <= i_cfg_wdata;
                pmds_pkg::CFG_PRECHARGE_WAIT: r_cfg.precharge_wait <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    pmds_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_opcode     (i_s_axis_tuser),
        .i_row        (i_s_axis_tdata[11:0]),
        .i_column     (i_s_axis_tdata[23:12]),
        .i_write_data (i_s_axis_tdata[31:24]),
        .i_close_row  (i_s_axis_tlast),
        .o_push       (w_push),
        .o_desc       (w_front_desc)
    );

    pmds_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_front_desc),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_desc  (w_head_desc)
    );

    pmds_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_desc  (w_head_desc),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_phase (w_phase)
    );

    assign o_m_axis_tdata = {3'b000, w_phase.hold_cycles, w_phase.sample_data,
                             w_phase.drive_data, w_phase.data_out, w_phase.addr_out,
                             w_phase.we_n, w_phase.cas_n, w_phase.ras_n};
    assign o_m_axis_tlast = w_phase.last;

endmodule

@@ rtl/pmds_front.sv @@
// ----------------------------------------------------------------------------
// pmds_front
// Decodes requests, tracks the open row and builds the phase plan.
// ----------------------------------------------------------------------------
module pmds_front #(
    parameter int unsigned ADDR_BITS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [2:0]                     i_opcode,
    input  logic [pmds_pkg::ADDR_W-1:0]    i_row,
    input  logic [pmds_pkg::ADDR_W-1:0]    i_column,
    input  logic [pmds_pkg::DATA_W-1:0]    i_write_data,
    input  logic                           i_close_row,
    output logic                           o_push,
    output pmds_pkg::t_desc                o_desc
);

    logic                 r_open;
    logic [ADDR_BITS-1:0] r_open_row;
    logic                 n_open;
    logic [ADDR_BITS-1:0] n_open_row;

    logic                 w_valid_op;
    logic                 w_page;
    logic                 w_write;
    logic                 w_refresh;
    logic                 w_close_first;
    logic [ADDR_BITS-1:0] w_row;
    logic [pmds_pkg::ADDR_W-1:0] w_row_ext;
    logic [pmds_pkg::ADDR_W-1:0] w_col_ext;
    logic [pmds_pkg::ADDR_W-1:0] w_open_ext;

    always_comb begin
        w_valid_op = 1'b1;
        w_page     = 1'b0;
        w_write    = 1'b0;
        w_refresh  = 1'b0;
        unique case (i_opcode)
            pmds_pkg::OP_READ: begin
            end
            pmds_pkg::OP_WRITE: begin
                w_write = 1'b1;
            end
            pmds_pkg::OP_PAGE_READ: begin
                w_page = 1'b1;
            end
            pmds_pkg::OP_PAGE_WRITE: begin
                w_page  = 1'b1;
                w_write = 1'b1;
            end
            pmds_pkg::OP_REFRESH: begin
                w_refresh = 1'b1;
            end
            default: begin
                w_valid_op = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_row_ext                 = '0;
        w_col_ext                 = '0;
        w_open_ext                = '0;
        w_row_ext[ADDR_BITS-1:0]  = i_row[ADDR_BITS-1:0];
        w_col_ext[ADDR_BITS-1:0]  = i_column[ADDR_BITS-1:0];
        w_open_ext[ADDR_BITS-1:0] = r_open_row;
    end

    assign w_row         = i_row[ADDR_BITS-1:0];
    assign w_close_first = r_open && !(w_page && (r_open_row == w_row));

    assign o_push = i_accept && w_valid_op;

    always_comb begin
        o_desc.is_refresh  = w_refresh;
        o_desc.is_write    = w_write;
        o_desc.drive_row   = w_write && !w_page;
        o_desc.close_first = w_close_first;
        o_desc.need_row    = !(r_open && !w_close_first);
        o_desc.end_close   = !(w_page && !i_close_row);
        o_desc.close_addr  = w_open_ext;
        o_desc.row         = w_row_ext;
        o_desc.column      = w_col_ext;
        o_desc.write_data  = i_write_data;
    end

    always_comb begin
        n_open     = r_open;
        n_open_row = r_open_row;
        if (o_push) begin
            if (w_refresh) begin
                n_open = 1'b0;
            end else begin
                n_open     = w_page && !i_close_row;
                n_open_row = w_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_open_row <= '0;
        end else begin
            r_open     <= n_open;
            r_open_row <= n_open_row;
        end
    end

endmodule

@@ rtl/pmds_fifo.sv @@
// ----------------------------------------------------------------------------
// pmds_fifo
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module pmds_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pmds_pkg::t_desc i_desc,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output pmds_pkg::t_desc o_desc
);

    pmds_pkg::t_desc r_entry [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            n_wp;
    logic            n_rp;
    logic [1:0]      n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_desc  = r_entry[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = ~r_wp;
        end
        if (i_pop) begin
            n_rp = ~r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ rtl/pmds_back.sv @@
// ----------------------------------------------------------------------------
// pmds_back
// Phase sequencer: walks the head request's plan, one word a cycle when ready.
// ----------------------------------------------------------------------------
module pmds_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pmds_pkg::t_cfg  i_cfg,
    input  logic            i_empty,
    input  pmds_pkg::t_desc i_desc,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output pmds_pkg::t_phase o_phase
);

    pmds_pkg::t_state r_state;
    pmds_pkg::t_state n_state;
    pmds_pkg::t_state w_cur;
    pmds_pkg::t_state w_after_close;

    logic             r_valid;
    pmds_pkg::t_phase r_phase;
    pmds_pkg::t_phase w_phase;
    logic             w_emit;

    assign w_emit = !i_empty && (!r_valid || i_ready);
    assign o_pop  = w_emit && w_phase.last;

    always_comb begin
        if (i_desc.is_refresh) begin
            w_after_close = pmds_pkg::ST_REF_CAS;
        end else if (i_desc.need_row) begin
            w_after_close = pmds_pkg::ST_ROW_SETUP;
        end else begin
            w_after_close = pmds_pkg::ST_COLUMN;
        end
        if (r_state == pmds_pkg::ST_IDLE) begin
            w_cur = i_desc.close_first ? pmds_pkg::ST_CLOSE : w_after_close;
        end else begin
            w_cur = r_state;
        end
    end

    // next state
    always_comb begin
        n_state = w_cur;
        unique case (w_cur)
            pmds_pkg::ST_CLOSE:     n_state = w_after_close;
            pmds_pkg::ST_ROW_SETUP: n_state = pmds_pkg::ST_RAS;
            pmds_pkg::ST_RAS:       n_state = pmds_pkg::ST_COLUMN;
            pmds_pkg::ST_COLUMN:    n_state = pmds_pkg::ST_CAS_LOW;
            pmds_pkg::ST_CAS_LOW:   n_state = pmds_pkg::ST_CAS_HIGH;
            pmds_pkg::ST_CAS_HIGH:
                n_state = i_desc.end_close ? pmds_pkg::ST_PRECHARGE : pmds_pkg::ST_IDLE;
            pmds_pkg::ST_PRECHARGE: n_state = pmds_pkg::ST_IDLE;
            pmds_pkg::ST_REF_CAS:   n_state = pmds_pkg::ST_REF_RAS;
            pmds_pkg::ST_REF_RAS:   n_state = pmds_pkg::ST_REF_PRE;
            pmds_pkg::ST_REF_PRE:   n_state = pmds_pkg::ST_IDLE;
            default:                n_state = pmds_pkg::ST_IDLE;
        endcase
    end

    // phase word
    always_comb begin
        w_phase = '0;
        w_phase.ras_n = 1'b1;
        w_phase.cas_n = 1'b1;
        w_phase.we_n  = 1'b1;
        unique case (w_cur)
            pmds_pkg::ST_CLOSE: begin
                w_phase.addr_out    = i_desc.close_addr;
                w_phase.hold_cycles = i_cfg.precharge_wait;
            end
            pmds_pkg::ST_ROW_SETUP, pmds_pkg::ST_RAS: begin
                w_phase.ras_n      = (w_cur == pmds_pkg::ST_ROW_SETUP);
                w_phase.we_n       = !i_desc.is_write;
                w_phase.addr_out   = i_desc.row;
                w_phase.drive_data = i_desc.drive_row;
                w_phase.data_out   = i_desc.drive_row ? i_desc.write_data : '0;
            end
            pmds_pkg::ST_COLUMN, pmds_pkg::ST_CAS_LOW, pmds_pkg::ST_CAS_HIGH: begin
                w_phase.ras_n    = 1'b0;
                w_phase.cas_n    = (w_cur != pmds_pkg::ST_CAS_LOW);
                w_phase.we_n     = !i_desc.is_write;
                w_phase.addr_out = i_desc.column;
                if (i_desc.is_write) begin
                    w_phase.drive_data = 1'b1;
                    w_phase.data_out   = i_desc.write_data;
                    if (w_cur == pmds_pkg::ST_CAS_LOW) begin
                        w_phase.hold_cycles = i_cfg.cas_wait;
                    end
                end else if (w_cur == pmds_pkg::ST_CAS_LOW) begin
                    w_phase.sample_data = !i_cfg.edo_mode;
                    w_phase.hold_cycles = i_cfg.cac_wait;
                end else if (w_cur == pmds_pkg::ST_CAS_HIGH) begin
                    w_phase.sample_data = i_cfg.edo_mode;
                end
            end
            pmds_pkg::ST_PRECHARGE: begin
                w_phase.addr_out    = i_desc.column;
                w_phase.hold_cycles = i_cfg.precharge_wait;
            end
            pmds_pkg::ST_REF_CAS: begin
                w_phase.cas_n = 1'b0;
            end
            pmds_pkg::ST_REF_RAS: begin
                w_phase.ras_n       = 1'b0;
                w_phase.cas_n       = 1'b0;
                w_phase.hold_cycles = i_cfg.ras_wait;
            end
            pmds_pkg::ST_REF_PRE: begin
                w_phase.hold_cycles = i_cfg.precharge_wait;
            end
            default: begin
            end
        endcase
        w_phase.last = (n_state == pmds_pkg::ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmds_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_state <= n_state;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_phase <= w_phase;
        end
    end

    assign o_valid = r_valid;
    assign o_phase = r_phase;

endmodule
